// ===== hdl/mcct_pkg.sv =====
package mcct_pkg;

  // Default sizing of the timer bank
  localparam int unsigned ChannelsDef   = 8;
  localparam int unsigned TicksPerMsDef = 2;

  // Field widths fixed by the item layout
  localparam int unsigned OpW    = 3;
  localparam int unsigned ChW    = 4;
  localparam int unsigned DurW   = 32;
  localparam int unsigned MsW    = 32;
  localparam int unsigned EnW    = 8;
  localparam int unsigned InDataW  = 40;  // op + channel + duration, padded to bytes
  localparam int unsigned OutDataW = 40;  // channel + elapsed_ms, padded to bytes

  // Operation codes of an input item
  typedef enum logic [OpW-1:0] {
    OP_TICK        = 3'd0,
    OP_START_MS    = 3'd1,
    OP_START_TICKS = 3'd2,
    OP_STOP        = 3'd3,
    OP_READ        = 3'd4
  } op_e;

  // Result kinds
  localparam logic KIND_EXPIRY = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  // One result item held between scan and output
  typedef struct packed {
    logic           kind;
    logic [ChW-1:0] channel;
    logic [MsW-1:0] elapsed_ms;
  } result_t;

endpackage

// ===== hdl/multi_channel_countdown_timer.sv =====
// Channel   | Direction | Handshake                      | Payload
// s_axis    | in        | s_axis_tvalid / s_axis_tready  | operation, channel, duration
// m_axis    | out       | m_axis_tvalid / m_axis_tready  | channel_out, elapsed_ms, kind, last
// cfg       | in        | cfg_we_i (no wait)             | callback_enable
//
// Start, stop and unused operations are taken while idle. A read is accepted, then the
// drain state releases its result. A tick is accepted, then a shared decrement/compare
// unit steps one channel per cycle unless held; drain sends the last result with tlast.
// A stalled output stops the scan only when a third result has no place to go.
// Reset clears all channels (not running, elapsed zero) and enables all callbacks.
module multi_channel_countdown_timer
  import mcct_pkg::*;
#(
  parameter int unsigned CHANNELS     = ChannelsDef,   // 1 .. 16
  parameter int unsigned TICKS_PER_MS = TicksPerMsDef  // 1 .. 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [EnW-1:0]      cfg_wdata_i,     // callback_enable
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,    // [2:0] operation, [6:3] channel,
                                               // [38:7] duration, [39] zero
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,    // [3:0] channel_out, [35:4] elapsed_ms,
                                               // [39:36] zero
  output logic                m_axis_tuser,    // [0] kind
  output logic                m_axis_tlast
);

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned FrW  = (TICKS_PER_MS > 1) ? $clog2(TICKS_PER_MS) : 1;
  localparam logic [IdxW-1:0] IdxLast = IdxW'(CHANNELS - 1);
  localparam logic [FrW-1:0]  FracMax = FrW'(TICKS_PER_MS - 1);
  localparam logic [DurW-1:0] TpmWord = DurW'(TICKS_PER_MS);
  localparam logic [ChW:0]    ChanCnt = (ChW + 1)'(CHANNELS);

  // Input fields
  logic [OpW-1:0]  in_op;
  logic [ChW-1:0]  in_ch;
  logic [DurW-1:0] in_dur;
  assign in_op  = s_axis_tdata[2:0];
  assign in_ch  = s_axis_tdata[6:3];
  assign in_dur = s_axis_tdata[38:7];

  // Channel state: elapsed time kept as whole ms plus a tick fraction
  logic            running_q [CHANNELS];
  logic [DurW-1:0] rem_q     [CHANNELS];
  logic [MsW-1:0]  ms_q      [CHANNELS];
  logic [FrW-1:0]  frac_q    [CHANNELS];

  logic [EnW-1:0]  cb_en_q;
  state_e          state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            pend_valid_q, pend_valid_d;
  result_t         pend_q, pend_d;
  logic            out_valid_q, out_valid_d;
  logic            out_last_q, out_last_d;
  result_t         out_q, out_d;

  // Callback enable per channel; channels 8 and up have none
  logic [CHANNELS-1:0] en_vec;
  for (genvar g = 0; g < CHANNELS; g++) begin : gen_en
    if (g < EnW) begin : gen_bit
      assign en_vec[g] = cb_en_q[g];
    end else begin : gen_none
      assign en_vec[g] = 1'b0;
    end
  end

  // Decode the addressed channel
  logic            in_acc;
  logic            present;
  logic [IdxW-1:0] ch_idx;
  logic [DurW-1:0] dur_scaled;
  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign present    = {1'b0, in_ch} < ChanCnt;
  assign ch_idx     = in_ch[IdxW-1:0];
  assign dur_scaled = in_dur * TpmWord;

  // Shared step unit: decrement and compare one channel per cycle unless the scan is held
  logic            cur_run;
  logic [DurW-1:0] cur_rem, rem_dec, new_rem;
  logic [MsW-1:0]  cur_ms, new_ms;
  logic [FrW-1:0]  cur_frac, new_frac;
  logic            rem_nz, frac_wrap, expire, emit, out_free, scan_step;

  always_comb begin
    cur_run   = running_q[idx_q];
    cur_rem   = rem_q[idx_q];
    cur_ms    = ms_q[idx_q];
    cur_frac  = frac_q[idx_q];
    rem_nz    = cur_rem != '0;
    rem_dec   = cur_rem - DurW'(1);
    frac_wrap = cur_frac == FracMax;
    new_rem   = cur_rem;
    new_ms    = cur_ms;
    new_frac  = cur_frac;
    if (rem_nz) begin
      new_rem  = rem_dec;
      new_frac = frac_wrap ? '0 : cur_frac + FrW'(1);
      new_ms   = frac_wrap ? cur_ms + MsW'(1) : cur_ms;
    end
    expire = cur_run && (new_rem == '0);
    emit   = expire && en_vec[idx_q];
  end

  assign out_free  = !out_valid_q || m_axis_tready;
  // Hold the scan only when a new result meets a full pending and output slot
  assign scan_step = (state_q == ST_SCAN) && !(emit && pend_valid_q && !out_free);

  // Sequencer, pending slot and output register
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_last_d   = out_last_q;
    out_d        = out_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_op)
            OP_TICK: begin
              state_d = ST_SCAN;
              idx_d   = '0;
            end
            OP_READ: begin
              state_d           = ST_DRAIN;
              pend_valid_d      = 1'b1;
              pend_d.kind       = KIND_READ;
              pend_d.channel    = in_ch;
              pend_d.elapsed_ms = present ? ms_q[ch_idx] : '1;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_step) begin
          if (emit) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_last_d  = 1'b0;
              out_d       = pend_q;
            end
            pend_valid_d      = 1'b1;
            pend_d.kind       = KIND_EXPIRY;
            pend_d.channel    = ChW'(idx_q);
            pend_d.elapsed_ms = new_ms;
          end
          if (idx_q == IdxLast) begin
            state_d = ST_DRAIN;
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end
      end
      ST_DRAIN: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_last_d   = 1'b1;
          out_d        = pend_q;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      out_last_q   <= 1'b0;
      cb_en_q      <= '1;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      out_last_q   <= out_last_d;
      if (cfg_we_i) begin
        cb_en_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  // Channel state: start/stop while idle, one channel per scan step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        running_q[i] <= 1'b0;
        ms_q[i]      <= '0;
        frac_q[i]    <= '0;
      end
    end else if (in_acc && present &&
                 (in_op == OP_START_MS || in_op == OP_START_TICKS)) begin
      running_q[ch_idx] <= 1'b1;
      ms_q[ch_idx]      <= '0;
      frac_q[ch_idx]    <= '0;
    end else if (in_acc && present && in_op == OP_STOP) begin
      running_q[ch_idx] <= 1'b0;
    end else if (scan_step && cur_run) begin
      ms_q[idx_q]   <= new_ms;
      frac_q[idx_q] <= new_frac;
      if (expire) begin
        running_q[idx_q] <= 1'b0;
      end
    end
  end

  // Remaining count needs no reset: it is only read while running
  always_ff @(posedge clk_i) begin
    if (in_acc && present && in_op == OP_START_MS) begin
      rem_q[ch_idx] <= dur_scaled;
    end else if (in_acc && present && in_op == OP_START_TICKS) begin
      rem_q[ch_idx] <= in_dur;
    end else if (scan_step && cur_run) begin
      rem_q[idx_q] <= new_rem;
    end
  end

  // Ports
  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_q.elapsed_ms, out_q.channel};
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== hdl/mcct_checker.sv =====
module mcct_checker
  import mcct_pkg::*;
#(
  parameter int unsigned CHANNELS = ChannelsDef
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [InDataW-1:0]  s_axis_tdata,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tuser,
  input logic                m_axis_tlast
);

  localparam logic [ChW:0] ChanCnt = (ChW + 1)'(CHANNELS);

  // A waiting result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A tick occupies the scan unit, so the next cycle takes no item
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tdata[2:0] == OP_TICK)
      |=> !s_axis_tready)
    else $error("item taken during tick scan");

  // A read is busy until its result is released
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tdata[2:0] == OP_READ)
      |=> !s_axis_tready)
    else $error("item taken before read result released");

  // A read gives exactly one result, which closes the run
  a_read_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_READ) |-> m_axis_tlast)
    else $error("read result without tlast");

  // A read of an absent channel reports all ones
  a_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_READ &&
     {1'b0, m_axis_tdata[3:0]} >= ChanCnt) |-> (m_axis_tdata[35:4] == '1))
    else $error("absent channel read not all ones");

endmodule

bind multi_channel_countdown_timer mcct_checker #(
  .CHANNELS(CHANNELS)
) u_mcct_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/countdown_result_checker.sv =====
module countdown_result_checker
  import mcct_pkg::*;
#(
  parameter int unsigned CHANNELS     = ChannelsDef,
  parameter int unsigned TICKS_PER_MS = TicksPerMsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [EnW-1:0]      cfg_wdata_i,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [2:0] operation, [6:3] channel,
                                              // [38:7] duration, [39] zero
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,   // [3:0] channel_out, [35:4] elapsed_ms,
                                              // [39:36] zero
  input  logic                m_axis_tuser,   // [0] kind
  input  logic                m_axis_tlast,
  output int unsigned         pending_o,
  output int unsigned         errors_o
);

  typedef struct packed {
    logic           kind;
    logic [ChW-1:0] channel;
    logic [MsW-1:0] elapsed_ms;
    logic           last;
  } timer_result_t;

  logic [EnW-1:0]  callback_mask;
  logic            chan_running   [CHANNELS];
  logic [DurW-1:0] chan_elapsed   [CHANNELS];
  logic [DurW-1:0] chan_remaining [CHANNELS];
  timer_result_t   awaited_results [$];
  timer_result_t   seen_result;
  timer_result_t   want_result;
  int unsigned     mismatch_count;

  // Apply one accepted item to the channel bank and queue the results it causes
  task automatic advance_bank(input logic [InDataW-1:0] data);
    logic [OpW-1:0]  op;
    logic [ChW-1:0]  ch;
    logic [DurW-1:0] dur;
    logic [MsW-1:0]  read_ms;
    logic            fired [CHANNELS];
    int              last_fired;
    op         = data[2:0];
    ch         = data[6:3];
    dur        = data[38:7];
    last_fired = -1;
    case (op)
      OP_TICK: begin
        // step every running channel, stop the ones that reach zero
        for (int i = 0; i < CHANNELS; i++) begin
          fired[i] = 1'b0;
          if (chan_running[i]) begin
            if (chan_remaining[i] != '0) begin
              chan_elapsed[i]   = chan_elapsed[i] + 1'b1;
              chan_remaining[i] = chan_remaining[i] - 1'b1;
            end
            if (chan_remaining[i] == '0) begin
              chan_running[i] = 1'b0;
              if (i < EnW && callback_mask[i]) begin
                fired[i]   = 1'b1;
                last_fired = i;
              end
            end
          end
        end
        // expiries go out in rising channel order, tlast on the final one
        for (int i = 0; i < CHANNELS; i++) begin
          if (fired[i]) begin
            awaited_results.push_back('{KIND_EXPIRY, ChW'(i),
                                        MsW'(chan_elapsed[i] / TICKS_PER_MS),
                                        (i == last_fired)});
          end
        end
      end
      OP_START_MS, OP_START_TICKS: begin
        if (ch < CHANNELS) begin
          chan_running[ch]   = 1'b1;
          chan_elapsed[ch]   = '0;
          chan_remaining[ch] = (op == OP_START_MS) ? DurW'(dur * TICKS_PER_MS) : dur;
        end
      end
      OP_STOP: begin
        if (ch < CHANNELS) begin
          chan_running[ch] = 1'b0;
        end
      end
      OP_READ: begin
        if (ch < CHANNELS) begin
          read_ms = MsW'(chan_elapsed[ch] / TICKS_PER_MS);
        end else begin
          read_ms = {MsW{1'b1}};
        end
        awaited_results.push_back('{KIND_READ, ch, read_ms, 1'b1});
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      callback_mask = {EnW{1'b1}};
      for (int i = 0; i < CHANNELS; i++) begin
        chan_running[i]   = 1'b0;
        chan_elapsed[i]   = '0;
        chan_remaining[i] = '0;
      end
      awaited_results.delete();
      mismatch_count = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      // compare the item leaving the block with the oldest expectation
      if (m_axis_tvalid && m_axis_tready) begin
        seen_result = '{m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[35:4], m_axis_tlast};
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, got kind %0d ch %0d ms %0d last %0d",
                   $time, seen_result.kind, seen_result.channel, seen_result.elapsed_ms,
                   seen_result.last);
          mismatch_count++;
        end else begin
          want_result = awaited_results.pop_front();
          if (seen_result !== want_result) begin
            $display("%0t: result mismatch: expected kind %0d ch %0d ms %0d last %0d",
                     $time, want_result.kind, want_result.channel, want_result.elapsed_ms,
                     want_result.last);
            $display("%0t:                  actual   kind %0d ch %0d ms %0d last %0d",
                     $time, seen_result.kind, seen_result.channel, seen_result.elapsed_ms,
                     seen_result.last);
            mismatch_count++;
          end
        end
      end
      if (cfg_we_i) begin
        callback_mask = cfg_wdata_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        advance_bank(s_axis_tdata);
      end
      pending_o <= awaited_results.size();
      errors_o  <= mismatch_count;
    end
  end

endmodule

// ===== tb/multi_channel_countdown_timer_test.sv =====
module multi_channel_countdown_timer_test;
  import mcct_pkg::*;

  localparam int unsigned CHANNELS      = ChannelsDef;
  localparam int unsigned TICKS_PER_MS  = TicksPerMsDef;
  localparam int unsigned PHASE_ITEMS   = 58;
  localparam int unsigned SETTLE_CYCLES = 2 * (CHANNELS + 1) + 8;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [EnW-1:0]      cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;    // [2:0] operation, [6:3] channel,
                                        // [38:7] duration, [39] zero
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;    // [3:0] channel_out, [35:4] elapsed_ms,
                                        // [39:36] zero
  logic                m_axis_tuser;    // [0] kind
  logic                m_axis_tlast;

  int unsigned send_gap_pct = 0;
  int unsigned stall_pct    = 0;
  int unsigned pending_results;
  int unsigned error_count;
  int unsigned cycle_count  = 0;

  multi_channel_countdown_timer #(
    .CHANNELS     (CHANNELS),
    .TICKS_PER_MS (TICKS_PER_MS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  countdown_result_checker #(
    .CHANNELS     (CHANNELS),
    .TICKS_PER_MS (TICKS_PER_MS)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .pending_o     (pending_results),
    .errors_o      (error_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("multi_channel_countdown_timer_test NOT OK");
    $finish;
  end

  // Random backpressure on the result side
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Offer one command item and hold it until accepted
  task automatic push_command(input logic [OpW-1:0] op, input logic [ChW-1:0] ch,
                              input logic [DurW-1:0] dur);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, dur, ch, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Hold off input until every awaited result is out, then let the scan settle
  task automatic drain_results(input int unsigned settle);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_callback_mask(input logic [EnW-1:0] mask);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mask;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly short timers on present channels with frequent ticks; some noise
  task automatic push_random_command(output bit counted);
    logic [OpW-1:0]  op;
    logic [ChW-1:0]  ch;
    logic [DurW-1:0] dur;
    int unsigned     pick;
    pick = $urandom_range(0, 99);
    if (pick < 38) begin
      op = OP_TICK;
    end else if (pick < 56) begin
      op = OP_START_TICKS;
    end else if (pick < 66) begin
      op = OP_START_MS;
    end else if (pick < 76) begin
      op = OP_STOP;
    end else if (pick < 93) begin
      op = OP_READ;
    end else begin
      op = OpW'($urandom_range(5, 7));
    end
    if ($urandom_range(0, 99) < 85) begin
      ch = ChW'($urandom_range(0, CHANNELS - 1));
    end else begin
      ch = ChW'($urandom_range(0, 15));
    end
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      dur = $urandom_range(0, 8);
    end else if (pick < 88) begin
      dur = $urandom;
    end else if (pick < 94) begin
      dur = 32'hFFFF_FFFF - $urandom_range(0, 2);
    end else begin
      // ms start that wraps to a short tick count
      dur = 32'h8000_0000 + $urandom_range(0, 3);
    end
    counted = (op <= OP_READ) &&
              !((op == OP_START_MS || op == OP_START_TICKS || op == OP_STOP) &&
                ch >= CHANNELS);
    push_command(op, ch, dur);
  endtask

  initial begin
    int unsigned    counted;
    bit             took;
    logic [EnW-1:0] mask;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reads before any start, absent channels, zero length, wrap
    push_command(OP_READ, 4'd0, 32'd0);
    push_command(OP_READ, 4'd15, 32'hFFFF_FFFF);
    push_command(OP_START_MS, 4'd0, 32'd3);
    push_command(OP_START_TICKS, 4'd1, 32'd0);
    push_command(OP_START_TICKS, 4'd2, 32'hFFFF_FFFF);
    push_command(OP_START_MS, 4'd3, 32'h8000_0001);
    push_command(OP_START_TICKS, 4'd7, 32'd1);
    push_command(OP_START_MS, 4'd5, 32'd0);
    push_command(OP_START_TICKS, 4'd9, 32'd5);
    push_command(OP_STOP, 4'd12, 32'd0);
    push_command(OP_TICK, 4'd0, 32'd0);
    push_command(OP_TICK, 4'd15, 32'hFFFF_FFFF);
    push_command(OP_STOP, 4'd2, 32'd0);
    push_command(OP_READ, 4'd2, 32'd0);
    push_command(OP_STOP, 4'd4, 32'd0);
    push_command(OpW'(5), 4'd6, 32'h1234_5678);
    push_command(OpW'(7), 4'd1, 32'hFFFF_FFFF);
    // every channel expires on one tick
    for (int c = 0; c < CHANNELS; c++) begin
      push_command(OP_START_TICKS, ChW'(c), DurW'(c % 2));
    end
    push_command(OP_TICK, 4'd0, 32'd0);
    push_command(OP_READ, 4'd6, 32'd0);

    // Random phases, each with its own idling pattern and callback mask
    for (int phase = 0; phase < 4; phase++) begin
      drain_results(SETTLE_CYCLES);
      case (phase)
        0: begin
          send_gap_pct = 0;
          stall_pct    = 0;
          mask         = EnW'($urandom);
        end
        1: begin
          send_gap_pct = 77;
          stall_pct    = 0;
          mask         = {EnW{1'b0}};
        end
        2: begin
          send_gap_pct = 0;
          stall_pct    = 77;
          mask         = {EnW{1'b1}};
        end
        default: begin
          send_gap_pct = 26;
          stall_pct    = 26;
          mask         = EnW'($urandom);
        end
      endcase
      write_callback_mask(mask);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        if (counted == PHASE_ITEMS / 2 || $urandom_range(0, 39) == 0) begin
          drain_results(0);
        end
        push_random_command(took);
        if (took) counted++;
      end
    end

    drain_results(SETTLE_CYCLES);
    if (error_count == 0) begin
      $display("multi_channel_countdown_timer_test OK");
    end else begin
      $display("multi_channel_countdown_timer_test NOT OK");
    end
    $finish;
  end

endmodule
